// ===== rtl/core/rbb_iou_pkg.sv =====
`timescale 1ns / 1ps

package rbb_iou_pkg;

    // fixed point formats
    localparam int COORD_FRAC_BITS = 8;
    localparam int TRIG_FRAC_BITS  = 14;

    // field widths
    localparam int BOX_W   = 24;
    localparam int LABEL_W = 16;
    localparam int TRIG_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int THR_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    // corner offset: x + w minus the source centre, plus sign
    localparam int SUM_W = BOX_W + 1;
    localparam int CTR_W = SIZE_W - 1 + COORD_FRAC_BITS;
    localparam int DX_W  = ((CTR_W > SUM_W) ? CTR_W : SUM_W) + 1;
    // rotation accumulator: two products of offset by trig value
    localparam int ACC_W = DX_W + TRIG_W + 1;
    // rotated coordinate, saturated to +/- 2^30
    localparam int COORD_W = 32;
    localparam int FRAME_W = SIZE_W + COORD_FRAC_BITS;

    // shared multiplier operands
    localparam int MUL_W  = 30;
    localparam int PROD_W = 2 * MUL_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 3'd6;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT,
        OP_FIN,
        OP_BOX,
        OP_AREA,
        OP_UNION,
        OP_THR,
        OP_DECIDE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] corner;
        logic [1:0] sub;
    } t_cmd;

    // box payload, first field in the highest bits
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [BOX_W-1:0]   h;
        logic [BOX_W-1:0]   w;
        logic [BOX_W-1:0]   y;
        logic [BOX_W-1:0]   x;
    } t_box;

    typedef struct packed {
        t_box data;
        logic kept;
        logic last;
    } t_result;

endpackage

// ===== rtl/core/rbb_iou_ctrl.sv =====
`timescale 1ns / 1ps

module rbb_iou_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output rbb_iou_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_FIN,
        S_BOX,
        S_AREA,
        S_UNION,
        S_THR,
        S_DECIDE
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_corner, n_corner;
    logic [1:0] r_sub, n_sub;
    logic       r_ovalid, n_ovalid;
    logic       w_accept;
    logic       w_slot_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign w_accept    = i_s_tvalid && (r_state == S_IDLE);
    assign w_slot_free = !r_ovalid || i_m_tready;

    // command decode
    always_comb begin
        o_cmd.corner = r_corner;
        o_cmd.sub    = r_sub;
        case (r_state)
            S_IDLE:   o_cmd.op = w_accept ? rbb_iou_pkg::OP_LOAD : rbb_iou_pkg::OP_NONE;
            S_ROT:    o_cmd.op = rbb_iou_pkg::OP_ROT;
            S_FIN:    o_cmd.op = rbb_iou_pkg::OP_FIN;
            S_BOX:    o_cmd.op = rbb_iou_pkg::OP_BOX;
            S_AREA:   o_cmd.op = rbb_iou_pkg::OP_AREA;
            S_UNION:  o_cmd.op = rbb_iou_pkg::OP_UNION;
            S_THR:    o_cmd.op = rbb_iou_pkg::OP_THR;
            S_DECIDE: o_cmd.op = w_slot_free ? rbb_iou_pkg::OP_DECIDE : rbb_iou_pkg::OP_NONE;
            default:  o_cmd.op = rbb_iou_pkg::OP_NONE;
        endcase
    end

    // sequencing
    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        n_sub    = r_sub;
        n_ovalid = r_ovalid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_ROT;
                    n_corner = '0;
                    n_sub    = '0;
                end
            end
            S_ROT: begin
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_sub = '0;
                if (r_corner == 2'd3) begin
                    n_state  = S_BOX;
                    n_corner = '0;
                end else begin
                    n_state  = S_ROT;
                    n_corner = r_corner + 2'd1;
                end
            end
            S_BOX: begin
                n_state = S_AREA;
                n_sub   = '0;
            end
            S_AREA: begin
                if (r_sub == 2'd2) begin
                    n_state = S_UNION;
                    n_sub   = '0;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            S_UNION: begin
                n_state = S_THR;
                n_sub   = '0;
            end
            S_THR: begin
                if (r_sub == 2'd1) begin
                    n_state = S_DECIDE;
                    n_sub   = '0;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            S_DECIDE: begin
                if (w_slot_free) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= '0;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_sub    <= n_sub;
            r_ovalid <= n_ovalid;
        end
    end

    // a request always starts at the first corner
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ROT && r_corner == 2'd0 && r_sub == 2'd0))
        else $error("sequence did not start at first corner");

    // counters are parked while idle
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_corner == 2'd0 && r_sub == 2'd0))
        else $error("counters not cleared in idle");

    // a new result only comes out of the decide step
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DECIDE))
        else $error("result raised outside decide");

    // decide waits while the output slot is held
    a_decide_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_ovalid && !i_m_tready) |=> (r_state == S_DECIDE))
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/rbb_iou_datapath.sv =====
`timescale 1ns / 1ps

module rbb_iou_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rbb_iou_pkg::t_cmd                     i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [rbb_iou_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbb_iou_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  rbb_iou_pkg::t_box                     i_box,
    input  logic                                  i_last,
    output rbb_iou_pkg::t_result                  o_res
);

    localparam int DX_W    = rbb_iou_pkg::DX_W;
    localparam int ACC_W   = rbb_iou_pkg::ACC_W;
    localparam int COORD_W = rbb_iou_pkg::COORD_W;
    localparam int FRAME_W = rbb_iou_pkg::FRAME_W;
    localparam int MUL_W   = rbb_iou_pkg::MUL_W;
    localparam int PROD_W  = rbb_iou_pkg::PROD_W;
    localparam int BOX_W   = rbb_iou_pkg::BOX_W;
    localparam int PW_W    = 28;
    localparam int PP_W    = 2 * PW_W;
    localparam int FF_W    = 2 * FRAME_W;
    localparam int UNI_W   = PP_W + 1;
    localparam int LO_W    = 29;
    localparam int HI_W    = UNI_W - LO_W;
    localparam int TL_W    = rbb_iou_pkg::THR_W + LO_W;
    localparam int TH_W    = rbb_iou_pkg::THR_W + HI_W;
    localparam int CMP_W   = TH_W + LO_W + 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) << (rbb_iou_pkg::TRIG_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] LIMIT = ACC_W'(1) << 30;
    localparam logic [COORD_W-1:0] OUT_MAX = COORD_W'((1 << BOX_W) - 1);

    // configuration
    logic signed [15:0] r_cos, r_sin;
    logic [15:0]        r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [16:0]        r_thr;
    logic               r_any_kept;

    // per box working registers
    logic signed [DX_W-1:0]    r_dx0, r_dx1, r_dy0, r_dy1;
    logic [15:0]               r_label;
    logic                      r_last;
    logic signed [ACC_W-1:0]   r_acc_x, r_acc_y;
    logic signed [COORD_W-1:0] r_lx, r_hx, r_ly, r_hy;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [PW_W-1:0]           r_pw, r_ph;
    logic [FRAME_W-1:0]        r_iw, r_ih;
    logic [PP_W-1:0]           r_pp;
    logic [FF_W-1:0]           r_ff, r_ii;
    logic [UNI_W-1:0]          r_uni;
    logic [TL_W-1:0]           r_tl;
    logic [TH_W-1:0]           r_th;
    rbb_iou_pkg::t_result      r_res;

    // derived config values
    logic signed [DX_W-1:0]  w_scx, w_scy;
    logic signed [ACC_W-1:0] w_dcx, w_dcy;
    logic [FRAME_W-1:0]      w_fw, w_fh;

    assign w_scx = DX_W'(r_src_w[15:1]) << rbb_iou_pkg::COORD_FRAC_BITS;
    assign w_scy = DX_W'(r_src_h[15:1]) << rbb_iou_pkg::COORD_FRAC_BITS;
    assign w_dcx = ACC_W'(r_dst_w[15:1]) << rbb_iou_pkg::COORD_FRAC_BITS;
    assign w_dcy = ACC_W'(r_dst_h[15:1]) << rbb_iou_pkg::COORD_FRAC_BITS;
    assign w_fw  = FRAME_W'(r_dst_w) << rbb_iou_pkg::COORD_FRAC_BITS;
    assign w_fh  = FRAME_W'(r_dst_h) << rbb_iou_pkg::COORD_FRAC_BITS;

    // shared multiplier operand select
    logic signed [DX_W-1:0]   w_dxi, w_dyj;
    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;

    assign w_dxi = i_cmd.corner[0] ? r_dx1 : r_dx0;
    assign w_dyj = i_cmd.corner[1] ? r_dy1 : r_dy0;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            rbb_iou_pkg::OP_ROT: begin
                w_ma = MUL_W'((i_cmd.sub == 2'd0 || i_cmd.sub == 2'd3) ? w_dxi : w_dyj);
                w_mb = MUL_W'((i_cmd.sub == 2'd0 || i_cmd.sub == 2'd2) ? r_cos : r_sin);
            end
            rbb_iou_pkg::OP_AREA: begin
                case (i_cmd.sub)
                    2'd0: begin
                        w_ma = MUL_W'({1'b0, r_pw});
                        w_mb = MUL_W'({1'b0, r_ph});
                    end
                    2'd1: begin
                        w_ma = MUL_W'({1'b0, w_fw});
                        w_mb = MUL_W'({1'b0, w_fh});
                    end
                    default: begin
                        w_ma = MUL_W'({1'b0, r_iw});
                        w_mb = MUL_W'({1'b0, r_ih});
                    end
                endcase
            end
            rbb_iou_pkg::OP_THR: begin
                w_ma = MUL_W'({1'b0, r_thr});
                w_mb = (i_cmd.sub == 2'd0) ? MUL_W'({1'b0, r_uni[LO_W-1:0]})
                                           : MUL_W'({1'b0, r_uni[UNI_W-1:LO_W]});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // corner rounding, recentering and saturation
    logic signed [ACC_W-1:0]   w_sx, w_sy;
    logic signed [COORD_W-1:0] w_cx, w_cy;

    always_comb begin
        w_sx = ((r_acc_x + ROUND_HALF) >>> rbb_iou_pkg::TRIG_FRAC_BITS) + w_dcx;
        w_sy = ((r_acc_y + ROUND_HALF) >>> rbb_iou_pkg::TRIG_FRAC_BITS) + w_dcy;
        if (w_sx > LIMIT) begin
            w_sx = LIMIT;
        end else if (w_sx < -LIMIT) begin
            w_sx = -LIMIT;
        end
        if (w_sy > LIMIT) begin
            w_sy = LIMIT;
        end else if (w_sy < -LIMIT) begin
            w_sy = -LIMIT;
        end
        w_cx = COORD_W'(w_sx);
        w_cy = COORD_W'(w_sy);
    end

    // box bounds and frame intersection
    logic signed [COORD_W:0] w_px, w_py, w_dw, w_dh, w_ex, w_ey, w_ix, w_iy;

    always_comb begin
        w_px = (r_lx > 0) ? (COORD_W+1)'(r_lx) : '0;
        w_py = (r_ly > 0) ? (COORD_W+1)'(r_ly) : '0;
        w_dw = (COORD_W+1)'(r_hx) - w_px;
        w_dh = (COORD_W+1)'(r_hy) - w_py;
        w_ex = (w_dw > 0) ? (COORD_W+1)'(r_hx) : w_px;
        w_ey = (w_dh > 0) ? (COORD_W+1)'(r_hy) : w_py;
        if (w_ex > $signed({1'b0, (COORD_W)'(w_fw)})) begin
            w_ex = $signed({1'b0, (COORD_W)'(w_fw)});
        end
        if (w_ey > $signed({1'b0, (COORD_W)'(w_fh)})) begin
            w_ey = $signed({1'b0, (COORD_W)'(w_fh)});
        end
        w_ix = w_ex - w_px;
        w_iy = w_ey - w_py;
    end

    // keep decision: inter * 2^16 >= threshold * union
    logic [CMP_W-1:0] w_lhs, w_rhs;
    logic             w_keep, w_fill;
    logic [BOX_W-1:0] w_ox, w_oy;

    assign w_lhs  = CMP_W'({r_ii, 16'b0});
    assign w_rhs  = CMP_W'({r_th, {LO_W{1'b0}}}) + CMP_W'(r_tl);
    assign w_keep = (r_uni != '0) && (w_lhs >= w_rhs);
    assign w_fill = r_last && !r_any_kept && !w_keep;
    assign w_ox   = ($unsigned(r_px) > OUT_MAX) ? BOX_W'(OUT_MAX) : BOX_W'(r_px);
    assign w_oy   = ($unsigned(r_py) > OUT_MAX) ? BOX_W'(OUT_MAX) : BOX_W'(r_py);

    // configuration and keep flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos      <= 16'sd16384;
            r_sin      <= '0;
            r_src_w    <= 16'd1;
            r_src_h    <= 16'd1;
            r_dst_w    <= 16'd1;
            r_dst_h    <= 16'd1;
            r_thr      <= 17'd32768;
            r_any_kept <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rbb_iou_pkg::CFG_COS:   r_cos   <= i_cfg_data[15:0];
                    rbb_iou_pkg::CFG_SIN:   r_sin   <= i_cfg_data[15:0];
                    rbb_iou_pkg::CFG_SRC_W: r_src_w <= i_cfg_data[15:0];
                    rbb_iou_pkg::CFG_SRC_H: r_src_h <= i_cfg_data[15:0];
                    rbb_iou_pkg::CFG_DST_W: r_dst_w <= i_cfg_data[15:0];
                    rbb_iou_pkg::CFG_DST_H: r_dst_h <= i_cfg_data[15:0];
                    rbb_iou_pkg::CFG_THR:   r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == rbb_iou_pkg::OP_DECIDE) begin
                r_any_kept <= r_last ? 1'b0 : (r_any_kept || w_keep);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rbb_iou_pkg::OP_LOAD: begin
                r_dx0   <= DX_W'(i_box.x) - w_scx;
                r_dx1   <= DX_W'(i_box.x) + DX_W'(i_box.w) - w_scx;
                r_dy0   <= DX_W'(i_box.y) - w_scy;
                r_dy1   <= DX_W'(i_box.y) + DX_W'(i_box.h) - w_scy;
                r_label <= i_box.label;
                r_last  <= i_last;
            end
            rbb_iou_pkg::OP_ROT: begin
                case (i_cmd.sub)
                    2'd0:    r_acc_x <= w_prod[ACC_W-1:0];
                    2'd1:    r_acc_x <= r_acc_x + w_prod[ACC_W-1:0];
                    2'd2:    r_acc_y <= w_prod[ACC_W-1:0];
                    default: r_acc_y <= r_acc_y - w_prod[ACC_W-1:0];
                endcase
            end
            rbb_iou_pkg::OP_FIN: begin
                if (i_cmd.corner == 2'd0) begin
                    r_lx <= w_cx;
                    r_hx <= w_cx;
                    r_ly <= w_cy;
                    r_hy <= w_cy;
                end else begin
                    if (w_cx < r_lx) r_lx <= w_cx;
                    if (w_cx > r_hx) r_hx <= w_cx;
                    if (w_cy < r_ly) r_ly <= w_cy;
                    if (w_cy > r_hy) r_hy <= w_cy;
                end
            end
            rbb_iou_pkg::OP_BOX: begin
                r_px <= COORD_W'(w_px);
                r_py <= COORD_W'(w_py);
                r_pw <= (w_dw > 0) ? PW_W'(w_dw) : '0;
                r_ph <= (w_dh > 0) ? PW_W'(w_dh) : '0;
                r_iw <= (w_ix > 0) ? FRAME_W'(w_ix) : '0;
                r_ih <= (w_iy > 0) ? FRAME_W'(w_iy) : '0;
            end
            rbb_iou_pkg::OP_AREA: begin
                case (i_cmd.sub)
                    2'd0:    r_pp <= w_prod[PP_W-1:0];
                    2'd1:    r_ff <= w_prod[FF_W-1:0];
                    default: r_ii <= w_prod[FF_W-1:0];
                endcase
            end
            rbb_iou_pkg::OP_UNION: begin
                r_uni <= UNI_W'(r_pp) + UNI_W'(r_ff) - UNI_W'(r_ii);
            end
            rbb_iou_pkg::OP_THR: begin
                if (i_cmd.sub == 2'd0) begin
                    r_tl <= w_prod[TL_W-1:0];
                end else begin
                    r_th <= w_prod[TH_W-1:0];
                end
            end
            rbb_iou_pkg::OP_DECIDE: begin
                r_res.data.x     <= w_keep ? w_ox : '0;
                r_res.data.y     <= w_keep ? w_oy : '0;
                r_res.data.w     <= w_keep ? BOX_W'(r_iw) : '0;
                r_res.data.h     <= w_keep ? BOX_W'(r_ih) : '0;
                r_res.data.label <= w_keep ? r_label : '0;
                r_res.kept       <= w_keep || w_fill;
                r_res.last       <= r_last;
            end
            default: ;
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/rotated_box_bounds_iou_filter_unit.sv =====
`timescale 1ns / 1ps

// Rotated box bounds with frame IoU filter.
// Input stream: one box request per transfer; tdata carries x, y, w, h
// (Q16.8) and the label, tlast marks the final box of an image.
// Output stream: one result per request; tdata carries the clipped box and
// label, tuser is the kept flag, tlast copies the request's tlast.
// Configuration: write enable, register index (0 cos, 1 sin, 2/3 source
// width/height, 4/5 frame width/height, 6 IoU threshold) and data; write
// only while no request is in flight.
// Sequence: one request at a time through a single shared multiplier: four
// corners of four products plus one bound update each, then box, three
// area products, union, two threshold products and the decision, where
// the result is registered. A new request is taken only after the
// previous one has left the decide step.
// The finished result sits in an output register, so the next request is
// accepted while the receiver stalls; a second result then waits in the
// decide step until the output register is free.
// Reset loads the register defaults (cos 1.0, sin 0, sizes 1, threshold
// 0.5) and clears the kept history and all handshake state.
module rotated_box_bounds_iou_filter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [16:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // box_x, box_y, box_w, box_h, box_label
    input  logic [111:0]  s_axis_tdata,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_x, out_y, out_w, out_h, out_label
    output logic [111:0]  m_axis_tdata,
    // kept
    output logic          m_axis_tuser,
    output logic          m_axis_tlast
);

    rbb_iou_pkg::t_cmd    w_cmd;
    rbb_iou_pkg::t_result w_res;

    rbb_iou_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    rbb_iou_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_box       (rbb_iou_pkg::t_box'(s_axis_tdata)),
        .i_last      (s_axis_tlast),
        .o_res       (w_res)
    );

    assign m_axis_tdata = w_res.data;
    assign m_axis_tuser = w_res.kept;
    assign m_axis_tlast = w_res.last;

endmodule
